>>> src/max_window_sum_average_macros.svh
// assertion macros shared by the max window sum average rtl
`ifndef MAX_WINDOW_SUM_AVERAGE_MACROS_SVH
`define MAX_WINDOW_SUM_AVERAGE_MACROS_SVH

// condition holds on every clock edge out of reset
`define MWSA_ASSERT_ALWAYS(lbl, expr, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (expr)) \
        else $error(msg);

// consequent holds in the same cycle as the antecedent
`define MWSA_ASSERT_IMPLY(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// consequent holds in the cycle after the antecedent
`define MWSA_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

>>> src/mwsa_pkg.sv
// shared types and constants of the max window sum average block
package mwsa_pkg;

    localparam int WINDOW_MAX_DEF = 1024;
    localparam int FRAC_BITS_DEF  = 16;

    localparam int CFG_W    = 11;
    localparam int SAMPLE_W = 16;
    localparam int BSUM_W   = 26;
    localparam int AVG_W    = 32;

    typedef enum logic [1:0] {
        DIV_IDLE,
        DIV_RUN,
        DIV_DONE
    } div_state_t;

    typedef struct packed {
        logic shift;
        logic tail;
    } cell_ctrl_t;

    typedef struct packed {
        logic signed [BSUM_W-1:0] best_sum;
        logic signed [AVG_W-1:0]  best_average;
        logic                     valid_res;
    } div_res_t;

endpackage

>>> src/max_window_sum_average.sv
// max window sum average: top level with window state, cell row, divider and output register
//
// Takes one signed sample per cycle while the input is not stalled; the last sample of a set
// launches the result. The window is a row of WINDOW_MAX sample cells that shift on each
// accepted beat, with the new sample entering at cell window_len-1 so that the head cell always
// holds the sample leaving the window. On the last beat the best sum goes to a restoring divider
// that retires one quotient bit per cycle, the sum width plus FRAC_BITS steps (43 by default).
// The input stalls from the last beat through the divide steps and the hand-off, until the
// result moves into the output register, from which it is presented. A set shorter than
// window_len skips the divide steps and stalls the input until its invalid result moves into
// the output register. A result that cannot leave a stalled output register holds the divider,
// and with it the input. The result waits in the output register while the next set streams in.
// Writing window_len clears the set in progress; out-of-range lengths act as 1 or WINDOW_MAX.
`include "max_window_sum_average_macros.svh"

module max_window_sum_average #(
    parameter int WINDOW_MAX = mwsa_pkg::WINDOW_MAX_DEF,
    parameter int FRAC_BITS  = mwsa_pkg::FRAC_BITS_DEF
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                cfg_valid,
    output logic                                cfg_ready,
    input  logic [mwsa_pkg::CFG_W-1:0]          window_len,
    input  logic                                in_valid,
    output logic                                in_stall,
    input  logic signed [mwsa_pkg::SAMPLE_W-1:0] sample,
    input  logic                                last,
    output logic                                out_valid,
    input  logic                                out_stall,
    output logic signed [mwsa_pkg::BSUM_W-1:0]  best_sum,
    output logic signed [mwsa_pkg::AVG_W-1:0]   best_average,
    output logic                                valid_res
);

    localparam int LEN_W = $clog2(WINDOW_MAX + 1);
    localparam int IDX_W = (WINDOW_MAX > 1) ? $clog2(WINDOW_MAX) : 1;
    localparam int SUM_W = mwsa_pkg::SAMPLE_W + LEN_W;

    logic [LEN_W-1:0]        len_reg, len_next;
    logic [IDX_W-1:0]        top_reg, top_next;
    logic [LEN_W-1:0]        fill_reg, fill_next;
    logic signed [SUM_W-1:0] sum_reg, sum_next;
    logic signed [SUM_W-1:0] best_reg, best_next;
    logic                    out_valid_reg, out_valid_next;
    mwsa_pkg::div_res_t      res_reg, res_next;

    logic                                cfg_wr;
    logic                                in_acc;
    logic [31:0]                         cfg_ext;
    logic [31:0]                         eff_len;
    logic signed [mwsa_pkg::SAMPLE_W-1:0] old_sample;
    logic signed [SUM_W-1:0]             s_ext;
    logic signed [SUM_W-1:0]             old_ext;
    logic signed [SUM_W-1:0]             sum_upd;
    logic signed [SUM_W-1:0]             best_upd;
    logic [LEN_W-1:0]                    fill_upd;

    logic               div_busy;
    logic               div_res_valid;
    logic               div_take;
    mwsa_pkg::div_res_t div_res;

    assign cfg_ready = 1'b1;
    assign cfg_wr    = cfg_valid && cfg_ready;
    assign in_stall  = div_busy;
    assign in_acc    = in_valid && !in_stall;

    // effective window length
    always_comb
    begin
        cfg_ext = 32'(window_len);
        if (cfg_ext == 32'd0)
        begin
            eff_len = 32'd1;
        end
        else if (cfg_ext > 32'(WINDOW_MAX))
        begin
            eff_len = 32'(WINDOW_MAX);
        end
        else
        begin
            eff_len = cfg_ext;
        end
    end

    // running sum and best window
    always_comb
    begin
        s_ext   = {{(SUM_W-mwsa_pkg::SAMPLE_W){sample[mwsa_pkg::SAMPLE_W-1]}}, sample};
        old_ext = {{(SUM_W-mwsa_pkg::SAMPLE_W){old_sample[mwsa_pkg::SAMPLE_W-1]}}, old_sample};

        fill_upd = fill_reg;
        sum_upd  = sum_reg;
        best_upd = best_reg;
        if (fill_reg < len_reg)
        begin
            fill_upd = fill_reg + LEN_W'(1);
            sum_upd  = sum_reg + s_ext;
            if (fill_upd == len_reg)
            begin
                best_upd = sum_upd;
            end
        end
        else
        begin
            sum_upd = sum_reg + s_ext - old_ext;
            if (sum_upd > best_reg)
            begin
                best_upd = sum_upd;
            end
        end

        len_next  = len_reg;
        top_next  = top_reg;
        fill_next = fill_reg;
        sum_next  = sum_reg;
        best_next = best_reg;
        if (cfg_wr)
        begin
            len_next  = LEN_W'(eff_len);
            top_next  = IDX_W'(eff_len - 32'd1);
            fill_next = '0;
            sum_next  = '0;
            best_next = '0;
        end
        else if (in_acc)
        begin
            if (last)
            begin
                fill_next = '0;
                sum_next  = '0;
                best_next = '0;
            end
            else
            begin
                fill_next = fill_upd;
                sum_next  = sum_upd;
                best_next = best_upd;
            end
        end
    end

    // output register
    always_comb
    begin
        div_take       = div_res_valid && (!out_valid_reg || !out_stall);
        out_valid_next = div_take || (out_valid_reg && out_stall);
        res_next       = div_take ? div_res : res_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            len_reg       <= LEN_W'(1);
            top_reg       <= '0;
            fill_reg      <= '0;
            sum_reg       <= '0;
            best_reg      <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            len_reg       <= len_next;
            top_reg       <= top_next;
            fill_reg      <= fill_next;
            sum_reg       <= sum_next;
            best_reg      <= best_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        res_reg <= res_next;
    end

    mwsa_chain #(
        .WINDOW_MAX (WINDOW_MAX),
        .IDX_W      (IDX_W)
    ) u_chain (
        .clk     (clk),
        .shift   (in_acc),
        .top_idx (top_reg),
        .din     (sample),
        .dout    (old_sample)
    );

    mwsa_div #(
        .SUM_W     (SUM_W),
        .LEN_W     (LEN_W),
        .FRAC_BITS (FRAC_BITS)
    ) u_div (
        .clk        (clk),
        .rst_n      (rst_n),
        .start      (in_acc && last),
        .start_best (best_upd),
        .start_len  (len_reg),
        .start_ok   (fill_upd >= len_reg),
        .take       (div_take),
        .busy       (div_busy),
        .res_valid  (div_res_valid),
        .res        (div_res)
    );

    assign out_valid    = out_valid_reg;
    assign best_sum     = res_reg.best_sum;
    assign best_average = res_reg.best_average;
    assign valid_res    = res_reg.valid_res;

    `MWSA_ASSERT_ALWAYS(a_fill_le_len, fill_reg <= len_reg, "fill count above window length")
    `MWSA_ASSERT_NEXT(a_last_starts_div, in_acc && last, div_busy, "last beat not dividing")
    `MWSA_ASSERT_NEXT(a_last_clears, in_acc && last, fill_reg == '0 && sum_reg == '0, "set kept")
    `MWSA_ASSERT_ALWAYS(a_len_nz, len_reg != '0, "zero window length")

endmodule

>>> src/mwsa_cell.sv
// one window cell: holds a sample and passes it toward the head on each beat
module mwsa_cell (
    input  logic                                clk,
    input  mwsa_pkg::cell_ctrl_t                ctrl,
    input  logic signed [mwsa_pkg::SAMPLE_W-1:0] din_new,
    input  logic signed [mwsa_pkg::SAMPLE_W-1:0] din_next,
    output logic signed [mwsa_pkg::SAMPLE_W-1:0] q
);

    logic signed [mwsa_pkg::SAMPLE_W-1:0] data_reg;
    logic signed [mwsa_pkg::SAMPLE_W-1:0] data_next;

    always_comb
    begin
        data_next = data_reg;
        if (ctrl.shift)
        begin
            data_next = ctrl.tail ? din_new : din_next;
        end
    end

    always_ff @(posedge clk)
    begin
        data_reg <= data_next;
    end

    assign q = data_reg;

endmodule

>>> src/mwsa_chain.sv
// row of window cells; the head cell holds the sample leaving the window
module mwsa_chain #(
    parameter int WINDOW_MAX = mwsa_pkg::WINDOW_MAX_DEF,
    parameter int IDX_W      = (WINDOW_MAX > 1) ? $clog2(WINDOW_MAX) : 1
) (
    input  logic                                clk,
    input  logic                                shift,
    input  logic [IDX_W-1:0]                    top_idx,
    input  logic signed [mwsa_pkg::SAMPLE_W-1:0] din,
    output logic signed [mwsa_pkg::SAMPLE_W-1:0] dout
);

    logic signed [mwsa_pkg::SAMPLE_W-1:0] cell_q [WINDOW_MAX];

    for (genvar i = 0; i < WINDOW_MAX; i++)
    begin : g_cell
        mwsa_pkg::cell_ctrl_t                ctrl;
        logic signed [mwsa_pkg::SAMPLE_W-1:0] upper;

        // shift in the upper bit, tail in the lower bit
        assign ctrl = {shift, (IDX_W'(i) == top_idx)};

        if (i == WINDOW_MAX - 1)
        begin : g_end
            assign upper = din;
        end
        else
        begin : g_mid
            assign upper = cell_q[i+1];
        end

        mwsa_cell u_cell (
            .clk      (clk),
            .ctrl     (ctrl),
            .din_new  (din),
            .din_next (upper),
            .q        (cell_q[i])
        );
    end

    assign dout = cell_q[0];

endmodule

>>> src/mwsa_div.sv
// serial floor divider producing the saturated best sum and q-format average
`include "max_window_sum_average_macros.svh"

module mwsa_div #(
    parameter int SUM_W     = 27,
    parameter int LEN_W     = 11,
    parameter int FRAC_BITS = mwsa_pkg::FRAC_BITS_DEF
) (
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    start,
    input  logic signed [SUM_W-1:0] start_best,
    input  logic [LEN_W-1:0]        start_len,
    input  logic                    start_ok,
    input  logic                    take,
    output logic                    busy,
    output logic                    res_valid,
    output mwsa_pkg::div_res_t      res
);

    localparam int MAG_W = SUM_W + FRAC_BITS;
    localparam int CNT_W = $clog2(MAG_W + 1);

    localparam logic signed [63:0] BSUM_HI = (64'sd1 <<< (mwsa_pkg::BSUM_W - 1)) - 64'sd1;
    localparam logic signed [63:0] BSUM_LO = -(64'sd1 <<< (mwsa_pkg::BSUM_W - 1));
    localparam logic [63:0]        AVG_POS = (64'd1 << (mwsa_pkg::AVG_W - 1)) - 64'd1;
    localparam logic [63:0]        AVG_NEG = 64'd1 << (mwsa_pkg::AVG_W - 1);

    mwsa_pkg::div_state_t state_reg, state_next;

    logic [CNT_W-1:0]                 cnt_reg, cnt_next;
    logic [MAG_W-1:0]                 work_reg, work_next;
    logic [LEN_W-1:0]                 rem_reg, rem_next;
    logic [LEN_W-1:0]                 den_reg, den_next;
    logic                             neg_reg, neg_next;
    logic                             ok_reg, ok_next;
    logic signed [mwsa_pkg::BSUM_W-1:0] bsum_reg, bsum_next;

    logic [SUM_W-1:0]  mag;
    logic signed [63:0] best_ext;
    logic [LEN_W:0]    rem_sh;
    logic              ge;
    logic [63:0]       q_ext;
    logic [63:0]       q_rnd;
    logic [63:0]       q_neg;

    // next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            mwsa_pkg::DIV_IDLE:
            begin
                if (start)
                begin
                    state_next = start_ok ? mwsa_pkg::DIV_RUN : mwsa_pkg::DIV_DONE;
                end
            end
            mwsa_pkg::DIV_RUN:
            begin
                if (cnt_reg == CNT_W'(1))
                begin
                    state_next = mwsa_pkg::DIV_DONE;
                end
            end
            mwsa_pkg::DIV_DONE:
            begin
                if (take)
                begin
                    state_next = mwsa_pkg::DIV_IDLE;
                end
            end
            default:
            begin
                state_next = mwsa_pkg::DIV_IDLE;
            end
        endcase
    end

    // datapath
    always_comb
    begin
        best_ext  = {{(64-SUM_W){start_best[SUM_W-1]}}, start_best};
        mag       = start_best[SUM_W-1] ? SUM_W'(-start_best) : SUM_W'(start_best);
        rem_sh    = {rem_reg, work_reg[MAG_W-1]};
        ge        = (rem_sh >= {1'b0, den_reg});

        cnt_next  = cnt_reg;
        work_next = work_reg;
        rem_next  = rem_reg;
        den_next  = den_reg;
        neg_next  = neg_reg;
        ok_next   = ok_reg;
        bsum_next = bsum_reg;

        if (state_reg == mwsa_pkg::DIV_IDLE && start)
        begin
            cnt_next  = CNT_W'(MAG_W);
            work_next = MAG_W'(mag) << FRAC_BITS;
            rem_next  = '0;
            den_next  = start_len;
            neg_next  = start_best[SUM_W-1];
            ok_next   = start_ok;
            if (!start_ok)
            begin
                bsum_next = '0;
            end
            else if (best_ext > BSUM_HI)
            begin
                bsum_next = mwsa_pkg::BSUM_W'(BSUM_HI);
            end
            else if (best_ext < BSUM_LO)
            begin
                bsum_next = mwsa_pkg::BSUM_W'(BSUM_LO);
            end
            else
            begin
                bsum_next = best_ext[mwsa_pkg::BSUM_W-1:0];
            end
        end
        else if (state_reg == mwsa_pkg::DIV_RUN)
        begin
            cnt_next  = cnt_reg - CNT_W'(1);
            work_next = {work_reg[MAG_W-2:0], ge};
            rem_next  = ge ? LEN_W'(rem_sh - {1'b0, den_reg}) : rem_sh[LEN_W-1:0];
        end
    end

    // outputs
    always_comb
    begin
        q_ext = 64'(work_reg);
        q_rnd = q_ext + 64'(rem_reg != '0);
        q_neg = -q_rnd;

        busy      = (state_reg != mwsa_pkg::DIV_IDLE);
        res_valid = (state_reg == mwsa_pkg::DIV_DONE);

        res.best_sum     = bsum_reg;
        res.valid_res    = ok_reg;
        res.best_average = '0;
        if (ok_reg)
        begin
            if (neg_reg)
            begin
                res.best_average = (q_rnd > AVG_NEG) ? mwsa_pkg::AVG_W'(AVG_NEG)
                                                     : q_neg[mwsa_pkg::AVG_W-1:0];
            end
            else
            begin
                res.best_average = (q_ext > AVG_POS) ? mwsa_pkg::AVG_W'(AVG_POS)
                                                     : q_ext[mwsa_pkg::AVG_W-1:0];
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= mwsa_pkg::DIV_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_ff @(posedge clk)
    begin
        cnt_reg  <= cnt_next;
        work_reg <= work_next;
        rem_reg  <= rem_next;
        den_reg  <= den_next;
        neg_reg  <= neg_next;
        ok_reg   <= ok_next;
        bsum_reg <= bsum_next;
    end

    `MWSA_ASSERT_IMPLY(a_run_cnt, state_reg == mwsa_pkg::DIV_RUN, cnt_reg != '0, "divider running with zero count")
    `MWSA_ASSERT_IMPLY(a_rem_lt_den, state_reg == mwsa_pkg::DIV_RUN, rem_reg < den_reg, "remainder not below divisor")
    `MWSA_ASSERT_IMPLY(a_den_nz, state_reg != mwsa_pkg::DIV_IDLE, den_reg != '0, "zero divisor in divider")

endmodule

>>> tb/sv/testbench.sv
// self-checking testbench for max_window_sum_average with random sample sets and window lengths
module testbench;

    localparam int HOLD_OFF     = 64;
    localparam int CYCLE_LIMIT  = 500000;
    localparam int RANDOM_BEATS = 1400;

    typedef struct {
        logic signed [mwsa_pkg::SAMPLE_W-1:0] value;
        logic                                 is_last;
    } sample_beat_t;

    logic                                 clk = 1'b0;
    logic                                 rst_n = 1'b0;
    logic                                 cfg_valid = 1'b0;
    logic                                 cfg_ready;
    logic [mwsa_pkg::CFG_W-1:0]           window_len = 11'd1;
    logic                                 in_valid = 1'b0;
    logic                                 in_stall;
    logic signed [mwsa_pkg::SAMPLE_W-1:0] sample = '0;
    logic                                 last = 1'b0;
    logic                                 out_valid;
    logic                                 out_stall = 1'b0;
    logic signed [mwsa_pkg::BSUM_W-1:0]   best_sum;
    logic signed [mwsa_pkg::AVG_W-1:0]    best_average;
    logic                                 valid_res;

    sample_beat_t       pending_beats[$];
    mwsa_pkg::div_res_t expected_results[$];

    shortint                    win_samples[mwsa_pkg::WINDOW_MAX_DEF];
    int unsigned                win_pos;
    int unsigned                win_fill;
    longint                     win_sum;
    longint                     win_best;
    logic [mwsa_pkg::CFG_W-1:0] win_len_reg;

    int send_idle_pct = 0;
    int stall_pct = 0;
    int cycle_count = 0;
    int mismatches = 0;
    int beats_accepted = 0;
    int results_checked = 0;
    int cfg_writes = 0;
    int random_beats = 0;

    max_window_sum_average dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg_valid    (cfg_valid),
        .cfg_ready    (cfg_ready),
        .window_len   (window_len),
        .in_valid     (in_valid),
        .in_stall     (in_stall),
        .sample       (sample),
        .last         (last),
        .out_valid    (out_valid),
        .out_stall    (out_stall),
        .best_sum     (best_sum),
        .best_average (best_average),
        .valid_res    (valid_res)
    );

    initial
    begin
        forever #5 clk = ~clk;
    end

    function automatic int unsigned active_window();
        if (win_len_reg == '0)
            return 1;
        if (win_len_reg > mwsa_pkg::WINDOW_MAX_DEF)
            return mwsa_pkg::WINDOW_MAX_DEF;
        return 32'(win_len_reg);
    endfunction

    function automatic void clear_window();
        win_pos = 0;
        win_fill = 0;
        win_sum = 0;
        win_best = 0;
    endfunction

    function automatic longint saturate(input longint v, input longint lo, input longint hi);
        if (v < lo)
            return lo;
        if (v > hi)
            return hi;
        return v;
    endfunction

    // slide the window by one sample and queue the set result on the closing beat
    function automatic void track_sample(input logic signed [mwsa_pkg::SAMPLE_W-1:0] s,
                                         input logic is_last);
        int unsigned        len;
        int unsigned        pos;
        longint             divisor;
        longint             num;
        longint             quo;
        mwsa_pkg::div_res_t res;
        len = active_window();
        pos = win_pos % len;
        if (win_fill < len)
        begin
            win_sum += longint'(s);
            win_fill++;
            if (win_fill == len)
                win_best = win_sum;
        end
        else
        begin
            win_sum += longint'(s) - longint'(win_samples[pos]);
            if (win_sum > win_best)
                win_best = win_sum;
        end
        win_samples[pos] = s;
        win_pos = (pos + 1 == len) ? 0 : pos + 1;
        if (is_last)
        begin
            res = '0;
            if (win_fill >= len)
            begin
                divisor = len;
                num = win_best * (longint'(1) << mwsa_pkg::FRAC_BITS_DEF);
                quo = num / divisor;
                if (num < 0 && (num % divisor) != 0)
                    quo -= 1;
                res.valid_res = 1'b1;
                res.best_sum = mwsa_pkg::BSUM_W'(saturate(win_best, -64'sd33554432,
                                                          64'sd33554431));
                res.best_average = mwsa_pkg::AVG_W'(saturate(quo, -64'sd2147483648,
                                                             64'sd2147483647));
            end
            expected_results.push_back(res);
            clear_window();
        end
    endfunction

    task automatic report_mismatch(input string msg);
        mismatches++;
        if (mismatches <= 30)
            $display("mismatch at cycle %0d: %s", cycle_count, msg);
    endtask

    function automatic logic signed [mwsa_pkg::SAMPLE_W-1:0] pick_sample();
        case ($urandom_range(7))
            0: return 16'sh7fff;
            1: return 16'sh8000;
            default: return mwsa_pkg::SAMPLE_W'($urandom);
        endcase
    endfunction

    function automatic void push_beat(input logic signed [mwsa_pkg::SAMPLE_W-1:0] v,
                                      input logic l);
        sample_beat_t b;
        b.value = v;
        b.is_last = l;
        pending_beats.push_back(b);
    endfunction

    function automatic void queue_set(input int unsigned count, input bit close);
        for (int unsigned i = 0; i < count; i++)
            push_beat(pick_sample(), close && (i == count - 1));
        random_beats += count;
    endfunction

    // checked between edges so that the driver and monitor have settled
    task automatic settle();
        do
            @(negedge clk);
        while (pending_beats.size() != 0 || in_valid || expected_results.size() != 0);
        repeat (HOLD_OFF) @(posedge clk);
    endtask

    task automatic write_window_len(input logic [mwsa_pkg::CFG_W-1:0] value);
        @(posedge clk);
        cfg_valid <= 1'b1;
        window_len <= value;
        do
            @(posedge clk);
        while (!cfg_ready);
        cfg_valid <= 1'b0;
        win_len_reg = value;
        clear_window();
        cfg_writes++;
    endtask

    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("run stopped by the watchdog after %0d cycles", cycle_count);
            $display("TB_ERROR");
            $finish;
        end
    end

    always @(posedge clk or negedge rst_n)
    begin : sample_driver
        sample_beat_t nxt;
        if (!rst_n)
        begin
            in_valid <= 1'b0;
            sample <= '0;
            last <= 1'b0;
        end
        else
        begin
            if (in_valid && !in_stall)
            begin
                track_sample(sample, last);
                beats_accepted++;
            end
            if (!in_valid || !in_stall)
            begin
                if (pending_beats.size() != 0 && $urandom_range(99) >= send_idle_pct)
                begin
                    nxt = pending_beats.pop_front();
                    in_valid <= 1'b1;
                    sample <= nxt.value;
                    last <= nxt.is_last;
                end
                else
                    in_valid <= 1'b0;
            end
        end
    end

    always @(posedge clk)
    begin : result_monitor
        mwsa_pkg::div_res_t want;
        if (!rst_n)
            out_stall <= 1'b0;
        else
        begin
            if (out_valid && !out_stall)
            begin
                results_checked++;
                if (expected_results.size() == 0)
                    report_mismatch("result beat with no set pending");
                else
                begin
                    want = expected_results.pop_front();
                    if (best_sum !== want.best_sum)
                        report_mismatch($sformatf("best_sum %0d, want %0d",
                                                  best_sum, want.best_sum));
                    if (best_average !== want.best_average)
                        report_mismatch($sformatf("best_average %0d, want %0d",
                                                  best_average, want.best_average));
                    if (valid_res !== want.valid_res)
                        report_mismatch($sformatf("valid_res %0b, want %0b",
                                                  valid_res, want.valid_res));
                end
            end
            out_stall <= ($urandom_range(99) < stall_pct);
        end
    end

    initial
    begin : stimulus
        logic [mwsa_pkg::CFG_W-1:0] wl;
        int unsigned                eff;
        int unsigned                sets;
        int unsigned                count;
        int                         phase;
        win_len_reg = 11'd1;
        clear_window();
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;

        // window of one straight out of reset
        push_beat(16'sh7fff, 1'b1);
        push_beat(16'sh8000, 1'b1);
        push_beat(16'sh0000, 1'b0);
        push_beat(-16'sd1, 1'b0);
        push_beat(16'sd1, 1'b1);
        settle();

        write_window_len(11'd3);
        push_beat(16'sd5, 1'b1);
        push_beat(16'sh7fff, 1'b0);
        push_beat(16'sh7fff, 1'b0);
        push_beat(16'sh7fff, 1'b0);
        push_beat(16'sh8000, 1'b0);
        push_beat(16'sh8000, 1'b1);
        repeat (2) push_beat(16'sh8000, 1'b0);
        push_beat(16'sh8000, 1'b1);
        push_beat(16'sd1, 1'b0);
        push_beat(16'sd2, 1'b0);
        push_beat(-16'sd4, 1'b1);
        // unfinished set, dropped by the next length write
        push_beat(16'sd7, 1'b0);
        push_beat(16'sd8, 1'b0);
        settle();

        write_window_len(11'd0);
        push_beat(-16'sd5, 1'b0);
        push_beat(16'sd3, 1'b1);
        settle();

        phase = 0;
        while (phase < 10 || random_beats < RANDOM_BEATS)
        begin
            case (phase % 4)
                0:
                begin
                    send_idle_pct = 0;
                    stall_pct = 0;
                end
                1:
                begin
                    send_idle_pct = 62;
                    stall_pct = 0;
                end
                2:
                begin
                    send_idle_pct = 0;
                    stall_pct = 62;
                end
                default:
                begin
                    send_idle_pct = 24;
                    stall_pct = 24;
                end
            endcase
            if (phase == 3)
                wl = 11'd2047;
            else if (phase == 6)
                wl = mwsa_pkg::CFG_W'($urandom_range(1025, 2046));
            else if (phase == 9)
                wl = 11'd1024;
            else
            begin
                case ($urandom_range(9))
                    0: wl = '0;
                    1: wl = 11'd1;
                    2: wl = mwsa_pkg::CFG_W'($urandom_range(17, 64));
                    default: wl = mwsa_pkg::CFG_W'($urandom_range(2, 16));
                endcase
            end
            write_window_len(wl);
            eff = active_window();
            sets = (eff > 64) ? 3 : $urandom_range(1, 3);
            for (int unsigned s = 0; s < sets; s++)
            begin
                if (eff > 64)
                    count = (phase == 9 && s == 0) ? eff + $urandom_range(0, 6)
                                                   : $urandom_range(1, 12);
                else if ($urandom_range(4) == 0)
                    count = $urandom_range(1, eff);
                else
                    count = $urandom_range(eff, 3 * eff + 6);
                queue_set(count, 1'b1);
            end
            if ($urandom_range(2) == 0)
                queue_set($urandom_range(1, (eff > 64) ? 8 : eff), 1'b0);
            settle();
            phase++;
        end

        $display("%0d sample beats over %0d window length writes, %0d set results compared",
                 beats_accepted, cfg_writes, results_checked);
        if (mismatches == 0)
            $display("TB_OK");
        else
            $display("TB_ERROR");
        $finish;
    end

endmodule
